/* design/ftft_pkg.sv */
// Shared types and constants of the five-tuple flow table core.
// Used by five_tuple_flow_table_core; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ftft_pkg;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] ETH_LEN        = 16'd14;
  localparam logic [15:0] ETH_IP_MIN_LEN = 16'd34;
  localparam logic [5:0]  TCP_HDR_LEN    = 6'd20;
  localparam logic [5:0]  UDP_HDR_LEN    = 6'd8;

  localparam logic [31:0] RESET_LOCAL_IP  = 32'h0A2A00B2;
  localparam logic [15:0] RESET_TOLERANCE = 16'd10;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_LOCAL_IP   = 2'd0,
    CFG_TOLERANCE  = 2'd1,
    CFG_RECORD_TCP = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_index_t;

  // One flow entry as held in the data memory
  typedef struct packed {
    logic [63:0] addresses;      // source, destination
    logic [39:0] ports_protocol; // sport, dport, protocol
    logic [31:0] count;
    logic [62:0] last_time;
    logic [62:0] gap;
    logic [42:0] lengths;        // total, payload, ip header, transport header
  } entry_t;

  // XOR fold of the five-tuple before reduction to a set index
  function automatic logic [31:0] fold_hash(input logic [31:0] src, input logic [31:0] dst,
                                            input logic [15:0] sport,
                                            input logic [15:0] dport,
                                            input logic [7:0] proto);
    logic [31:0] x;
    x = src ^ dst ^ {sport, dport} ^ {24'd0, proto};
    x = x ^ {16'd0, x[31:16]};
    x = x ^ {8'd0, x[31:8]};
    return x;
  endfunction

endpackage
`default_nettype wire

/* design/ftft_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ftft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* design/five_tuple_flow_table_core.sv */
// Five-tuple flow table core: packet checks, set-associative flow lookup, LRU.
// Depends on ftft_pkg and ftft_ram.
`timescale 1ns / 1ps
`default_nettype none
// Raise start with a packet's header fields while busy is low; the request is
// taken at that edge. One result appears with done high for a single cycle and
// must be captured then. With a power-of-two set count a request reads the
// flow set and its valid/age row into a register, then looks up, updates and
// writes the set back; the next request may be given in the cycle done is
// high. With another set count the set index is reduced by a reciprocal
// multiplication: the quotient is registered first, then the remainder
// selects the set to read, before the lookup. After reset the valid/age
// memory is cleared, one set per cycle, with busy high; configuration writes
// are taken at any time.
module five_tuple_flow_table_core #(
  parameter int TABLE_ENTRIES = 1024,
  parameter int WAYS          = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] frame_length,
  input  wire logic [15:0] ether_type,
  input  wire logic [31:0] ip_source,
  input  wire logic [31:0] ip_dest,
  input  wire logic [7:0]  ip_protocol,
  input  wire logic [3:0]  ip_ihl,
  input  wire logic [15:0] ip_total_length,
  input  wire logic [15:0] source_port,
  input  wire logic [15:0] dest_port,
  input  wire logic [62:0] arrival_time,
  output logic             done,
  output logic             verdict,
  output logic             recorded,
  output logic             new_flow,
  output logic             evicted,
  output logic [31:0]      flow_count,
  output logic [62:0]      gap_ns,
  output logic [15:0]      payload_bytes
);

  localparam int SETS      = TABLE_ENTRIES / WAYS;
  localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGE_W     = WAY_W;
  localparam int META_W    = AGE_W + 1;
  localparam int ENTRY_W   = $bits(ftft_pkg::entry_t);
  localparam bit SETS_POW2 = ((SETS & (SETS - 1)) == 0);
  localparam int RECIP_SH  = 32 + SET_W;
  localparam longint unsigned RECIP =
    ((64'd1 << RECIP_SH) + 64'(SETS) - 64'd1) / 64'(SETS);

  typedef enum logic [2:0] {ST_CLR, ST_IDLE, ST_HASH, ST_RD, ST_LOOK} state_t;

  state_t state;
  logic   accept;

  // Configuration registers
  logic [31:0] local_ip;
  logic [15:0] tolerance;
  logic        record_tcp;

  // Captured request
  logic [15:0] r_frame, r_etype, r_tot, r_sport, r_dport;
  logic [31:0] r_src, r_dst;
  logic [7:0]  r_proto;
  logic [3:0]  r_ihl;
  logic [62:0] r_ts;
  logic [SET_W-1:0] set_idx;

  // Set reduction for non-power-of-two set counts, and the clear counter
  logic [31:0]      hash_word;
  logic [31:0]      quot;
  logic [64:0]      recip_prod;
  logic [31:0]      red_word;
  logic [SET_W-1:0] clr_cnt;

  logic [31:0]      port_hash;
  logic [SET_W-1:0] port_set;

  // Memory ports
  logic                      rd_en, data_we, meta_we;
  logic [SET_W-1:0]          rd_addr, meta_waddr;
  logic [WAYS*ENTRY_W-1:0]   data_rd, data_wr;
  logic [WAYS*META_W-1:0]    meta_rd, meta_wr;

  // Lookup results
  logic                 chk_drop, do_record, verdict_next;
  logic [15:0]          payload;
  logic [42:0]          len_word;
  ftft_pkg::entry_t     ent [WAYS];
  logic [WAYS-1:0]      vld;
  logic [AGE_W-1:0]     age [WAYS];
  logic                 hit, free_found;
  logic [WAY_W-1:0]     hit_way, free_way, old_way, way;
  logic [AGE_W-1:0]     best;
  logic [AGE_W:0]       old_age;
  ftft_pkg::entry_t     sel, upd;
  logic [31:0]          cnt_base;
  logic [62:0]          gap_out;
  logic                 rev_drop;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign port_hash = ftft_pkg::fold_hash(ip_source, ip_dest, source_port, dest_port,
                                         ip_protocol);
  assign port_set  = SET_W'(port_hash & 32'(SETS - 1));

  // Read on accept for power-of-two sets, else after reduction
  assign rd_en   = (accept && SETS_POW2) || (state == ST_RD);
  assign rd_addr = (state == ST_RD) ? red_word[SET_W-1:0] : port_set;

  // Quotient by reciprocal multiplication, then remainder by one multiply-subtract
  assign recip_prod = {33'd0, hash_word} * {32'd0, 33'(RECIP)};
  assign red_word   = hash_word - quot * 32'(SETS);

  // Packet checks and flow lookup
  always_comb begin
    logic [5:0]  iphl;
    logic [5:0]  thl;
    logic [16:0] pl;
    logic [6:0]  need;
    logic        pass;
    iphl = {r_ihl, 2'b00};
    thl  = (r_proto == ftft_pkg::PROTO_TCP) ? ftft_pkg::TCP_HDR_LEN : ftft_pkg::UDP_HDR_LEN;
    need = 7'(ftft_pkg::ETH_LEN) + 7'(iphl) + 7'(thl);
    pl   = {1'b0, r_tot} - 17'(iphl) - 17'(thl);
    chk_drop = 1'b0;
    pass     = 1'b0;
    payload  = 16'd0;
    priority if (r_frame < ftft_pkg::ETH_LEN) begin
      chk_drop = 1'b1;
    end else if (r_etype != ftft_pkg::ETHERTYPE_IPV4) begin
      pass = 1'b1;
    end else if (r_frame < ftft_pkg::ETH_IP_MIN_LEN) begin
      chk_drop = 1'b1;
    end else if (r_src != local_ip) begin
      pass = 1'b1;
    end else if (r_proto != ftft_pkg::PROTO_TCP && r_proto != ftft_pkg::PROTO_UDP) begin
      pass = 1'b1;
    end else if (r_frame < 16'(need)) begin
      chk_drop = 1'b1;
    end else begin
      payload = pl[16] ? 16'd0 : pl[15:0];
      pass    = (r_proto == ftft_pkg::PROTO_TCP) && !record_tcp;
    end
    do_record = !chk_drop && !pass;
    len_word  = {r_tot, payload, iphl, thl[4:0]};

    // Unpack the set
    for (int w = 0; w < WAYS; w++) begin
      ent[w] = data_rd[w*ENTRY_W +: ENTRY_W];
      vld[w] = meta_rd[w*META_W + AGE_W];
      age[w] = meta_rd[w*META_W +: AGE_W];
    end

    // Hit, first free way, oldest way
    hit = 1'b0;
    hit_way = '0;
    free_found = 1'b0;
    free_way = '0;
    old_way = '0;
    best = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && vld[w] && ent[w].addresses == {r_src, r_dst} &&
          ent[w].ports_protocol == {r_sport, r_dport, r_proto}) begin
        hit = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!free_found && !vld[w]) begin
        free_found = 1'b1;
        free_way = WAY_W'(w);
      end
      if (age[w] > best) begin
        best = age[w];
        old_way = WAY_W'(w);
      end
    end
    way = hit ? hit_way : (free_found ? free_way : old_way);
    sel = ent[way];
    old_age = hit ? {1'b0, age[way]} : (AGE_W+1)'(WAYS);

    // Age the younger valid ways, make the chosen way newest
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == way) begin
        meta_wr[w*META_W +: META_W] = {1'b1, AGE_W'(0)};
      end else if (vld[w] && {1'b0, age[w]} < old_age && age[w] < AGE_W'(WAYS - 1)) begin
        meta_wr[w*META_W +: META_W] = {1'b1, age[w] + AGE_W'(1)};
      end else begin
        meta_wr[w*META_W +: META_W] = {vld[w], age[w]};
      end
    end

    // Update the entry
    upd.addresses      = {r_src, r_dst};
    upd.ports_protocol = {r_sport, r_dport, r_proto};
    cnt_base  = hit ? sel.count : 32'd1;
    upd.count = (&cnt_base) ? cnt_base : cnt_base + 32'd1;
    if (!hit) begin
      sel.last_time = r_ts;
      sel.gap       = '0;
      sel.lengths   = '0;
    end
    rev_drop      = 1'b0;
    upd.last_time = r_ts;
    upd.lengths   = len_word;
    upd.gap       = sel.gap;
    if (r_ts >= sel.last_time) begin
      upd.gap = r_ts - sel.last_time;
    end else if ((sel.last_time - r_ts) > 63'(tolerance)) begin
      rev_drop      = 1'b1;
      upd.last_time = sel.last_time;
      upd.lengths   = sel.lengths;
    end
    gap_out = upd.gap;
    verdict_next = chk_drop || (do_record && rev_drop);

    for (int w = 0; w < WAYS; w++) begin
      data_wr[w*ENTRY_W +: ENTRY_W] = (WAY_W'(w) == way) ? upd : ent[w];
    end
  end

  assign data_we    = (state == ST_LOOK) && do_record;
  assign meta_we    = (state == ST_CLR) || data_we;
  assign meta_waddr = (state == ST_CLR) ? clr_cnt : set_idx;

  ftft_ram #(.WIDTH(WAYS*ENTRY_W), .DEPTH(SETS)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (set_idx),
    .wdata (data_wr),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (data_rd)
  );

  ftft_ram #(.WIDTH(WAYS*META_W), .DEPTH(SETS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata ((state == ST_CLR) ? '0 : meta_wr),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (meta_rd)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip   <= ftft_pkg::RESET_LOCAL_IP;
      tolerance  <= ftft_pkg::RESET_TOLERANCE;
      record_tcp <= 1'b0;
    end else if (cfg_write) begin
      unique case (ftft_pkg::cfg_index_t'(cfg_index))
        ftft_pkg::CFG_LOCAL_IP:   local_ip   <= cfg_data;
        ftft_pkg::CFG_TOLERANCE:  tolerance  <= cfg_data[15:0];
        ftft_pkg::CFG_RECORD_TCP: record_tcp <= cfg_data[0];
        ftft_pkg::CFG_UNUSED:     ;
      endcase
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      r_frame <= frame_length;
      r_etype <= ether_type;
      r_src   <= ip_source;
      r_dst   <= ip_dest;
      r_proto <= ip_protocol;
      r_ihl   <= ip_ihl;
      r_tot   <= ip_total_length;
      r_sport <= source_port;
      r_dport <= dest_port;
      r_ts    <= arrival_time;
    end
  end

  // Sequencer and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_CLR: begin
          clr_cnt <= clr_cnt + SET_W'(1);
          if (clr_cnt == SET_W'(SETS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            set_idx   <= port_set;
            hash_word <= port_hash;
            state     <= SETS_POW2 ? ST_LOOK : ST_HASH;
          end
        end
        ST_HASH: begin
          quot  <= 32'(recip_prod >> RECIP_SH);
          state <= ST_RD;
        end
        ST_RD: begin
          set_idx <= red_word[SET_W-1:0];
          state   <= ST_LOOK;
        end
        ST_LOOK: begin
          done          <= 1'b1;
          verdict       <= verdict_next;
          payload_bytes <= payload;
          recorded      <= do_record;
          new_flow      <= do_record && !hit;
          evicted       <= do_record && !hit && !free_found;
          flow_count    <= do_record ? upd.count : 32'd0;
          gap_ns        <= do_record ? gap_out : 63'd0;
          state         <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A result follows only a lookup cycle
  a_done_after_look: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_LOOK) else $error("result without lookup");

  // A taken request makes the core busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy) else $error("not busy after request");

  // Eviction implies a new, recorded flow
  a_evict_new: assert property (@(posedge clk) disable iff (rst)
    (done && evicted) |-> (new_flow && recorded)) else $error("eviction without new flow");

  // A recorded flow never reports a zero count
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && recorded) |-> flow_count != 32'd0) else $error("zero count on recorded flow");

endmodule
`default_nettype wire
